@@ sv/spt_pkg.sv @@
package spt_pkg;

  localparam int FRAC_BITS = 24;
  localparam int PHASE_W   = FRAC_BITS + 1;
  localparam int INDEX_W   = 16;
  localparam int NCOUNT_W  = 17;
  localparam int POS_W     = 32;
  localparam int DIFF_W    = POS_W + 1;
  // Horner terms stay below 2^10 in magnitude, 24 fraction bits, plus sign
  localparam int HORNER_W  = 35;
  // blend lies in [0, 1] plus rounding, signed with 24 fraction bits
  localparam int BLEND_W   = 27;
  // (end - start) * blend before adding start
  localparam int TAIL_W    = 35;

  localparam int COEF_5 = 126;
  localparam int COEF_6 = 420;
  localparam int COEF_7 = 540;
  localparam int COEF_8 = 315;
  localparam int COEF_9 = 70;

  localparam int HORNER_STEPS = 9;
  localparam int HORNER_COEF [HORNER_STEPS] =
    '{-COEF_8, COEF_7, -COEF_6, COEF_5, 0, 0, 0, 0, 0};

  typedef struct packed {
    logic [INDEX_W-1:0]      node_index;
    logic signed [POS_W-1:0] start_value;
    logic signed [POS_W-1:0] end_value;
  } spt_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    last_node;
  } spt_out_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  start_value;
    logic signed [DIFF_W-1:0] diff;
    logic                     last_node;
  } spt_side_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    spt_side_t          side;
  } spt_horner_t;

  typedef struct packed {
    logic signed [POS_W-1:0] start_value;
    logic                    last_node;
  } spt_tail_t;

endpackage

@@ sv/spt_div_cell.sv @@
module spt_div_cell #(
  parameter int LW  = 16,
  parameter int BIT = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [LW-1:0]                   last,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [LW-1:0]                   rem_in,
  input  logic [spt_pkg::PHASE_W-1:0]     num_in,
  input  logic [spt_pkg::PHASE_W-1:0]     quo_in,
  input  spt_pkg::spt_side_t              side_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [LW-1:0]                   rem_out,
  output logic [spt_pkg::PHASE_W-1:0]     num_out,
  output logic [spt_pkg::PHASE_W-1:0]     quo_out,
  output spt_pkg::spt_side_t              side_out
);
  import spt_pkg::*;

  logic [LW:0]        trial;
  logic [LW:0]        reduced;
  logic               fits;
  logic [PHASE_W-1:0] quo_next;

  // one restoring division step: bring down a dividend bit, try the divisor
  assign trial   = {rem_in, num_in[BIT]};
  assign fits    = (trial >= {1'b0, last});
  assign reduced = trial - {1'b0, last};

  always_comb begin
    quo_next      = quo_in;
    quo_next[BIT] = fits;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_out  <= fits ? reduced[LW-1:0] : trial[LW-1:0];
      num_out  <= num_in;
      quo_out  <= quo_next;
      side_out <= side_in;
    end
  end

endmodule

@@ sv/spt_mul_cell.sv @@
module spt_mul_cell #(
  parameter int AW   = 35,
  parameter int BW   = 26,
  parameter int OW   = 35,
  parameter int CW   = 1,
  parameter int COEF = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  input  logic [CW-1:0]        aux_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [OW-1:0] y,
  output logic [CW-1:0]        aux_out
);
  import spt_pkg::*;

  localparam int PW = AW + BW;
  localparam int MW = PW + 1 - FRAC_BITS;
  localparam int SW = (MW > OW ? MW : OW) + 2;
  localparam logic signed [SW-1:0] COEF_Q = SW'(longint'(COEF) <<< FRAC_BITS);
  localparam logic [PW:0] HALF = (PW + 1)'(1) << (FRAC_BITS - 1);

  logic [AW-1:0]        a_u;
  logic [AW-1:0]        a_mag;
  logic [BW-1:0]        b_u;
  logic [BW-1:0]        b_mag;

  logic                 v1;
  logic [PW-1:0]        prod;
  logic                 neg;
  logic [CW-1:0]        aux1;
  logic                 ready1;
  logic                 ready2;

  logic [PW:0]          rnd;
  logic [MW-1:0]        mag;
  logic signed [SW-1:0] mag_s;
  logic signed [SW-1:0] sum;

  // sign-magnitude product, rounded half away from zero
  assign a_u   = a;
  assign b_u   = b;
  assign a_mag = a_u[AW-1] ? (~a_u + 1'b1) : a_u;
  assign b_mag = b_u[BW-1] ? (~b_u + 1'b1) : b_u;

  assign ready2   = !out_valid || out_ready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      prod <= a_mag * b_mag;
      neg  <= a_u[AW-1] ^ b_u[BW-1];
      aux1 <= aux_in;
    end
  end

  assign rnd   = {1'b0, prod} + HALF;
  assign mag   = rnd[PW:FRAC_BITS];
  assign mag_s = signed'(SW'(mag));
  assign sum   = neg ? (COEF_Q - mag_s) : (COEF_Q + mag_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      y       <= sum[OW-1:0];
      aux_out <= aux1;
    end
  end

endmodule

@@ sv/smooth_polynomial_trajectory_point.sv @@
// Throughput: one item per cycle while result_ready holds; every stage holds one item.
// Flow: each stage loads when it is empty or its successor takes its item.
// Reset: rst is synchronous, active high; it empties the pipeline and sets
// the node count to 2 (last node index 1).
module smooth_polynomial_trajectory_point #(
  parameter int MAX_NODES = 65536
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [spt_pkg::NCOUNT_W-1:0]   cfg_data,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  spt_pkg::spt_in_t               item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output spt_pkg::spt_out_t              result
);
  import spt_pkg::*;

  // Pipeline, front to back:
  //   input    clamp the index, build the phase dividend, form end - start
  //   25 cells restoring divider, one phase bit per cell (k*2^24 + L/2) / L
  //   h0       first Horner term 70*p
  //   9 cells  multiply-round by p and add the next coefficient, product then output register
  //   1 cell   (end - start) * blend, rounded to 16 fraction bits
  //   output   add start, saturate, output register
  localparam int LW        = $clog2(MAX_NODES);
  localparam int CMPW      = (LW > NCOUNT_W ? LW : NCOUNT_W) + 1;
  localparam int KW        = (LW > INDEX_W ? LW : INDEX_W);
  localparam int DW        = INDEX_W + FRAC_BITS;
  localparam int DIV_CELLS = PHASE_W;
  localparam int HAW       = $bits(spt_horner_t);
  localparam int TAW       = $bits(spt_tail_t);
  localparam int SUM_W     = TAIL_W + 1;

  // ---------------------------------------------------------------------
  // Node count register, kept as the clamped last node index.
  // Counts of 0 or 1 act as 2; counts above MAX_NODES act as MAX_NODES.
  // ---------------------------------------------------------------------
  logic [CMPW-1:0] n_ext;
  logic [CMPW-1:0] n_sel;
  logic [LW-1:0]   last;

  always_comb begin
    n_ext = CMPW'(cfg_data);
    if (n_ext < CMPW'(2)) begin
      n_sel = CMPW'(2);
    end else if (n_ext > CMPW'(MAX_NODES)) begin
      n_sel = CMPW'(MAX_NODES);
    end else begin
      n_sel = n_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last <= LW'(1);
    end else if (cfg_we) begin
      last <= LW'(n_sel - CMPW'(1));
    end
  end

  // ---------------------------------------------------------------------
  // Input stage: an index past the end is clamped to the last node.
  // The dividend carries L/2 so the quotient rounds to nearest, halves up.
  // Since k <= L the quotient never exceeds 2^24, so the divider starts with
  // the dividend bits above the 25 quotient bits as its first remainder.
  // ---------------------------------------------------------------------
  logic [KW-1:0]      k_ext;
  logic [KW-1:0]      last_ext;
  logic               at_end;
  logic [INDEX_W-1:0] k_sel;
  logic [DW-1:0]      dividend;

  logic               va;
  logic [LW-1:0]      a_rem;
  logic [PHASE_W-1:0] a_num;
  spt_side_t          a_side;

  assign k_ext    = KW'(item.node_index);
  assign last_ext = KW'(last);
  assign at_end   = (k_ext >= last_ext);
  assign k_sel    = at_end ? last_ext[INDEX_W-1:0] : item.node_index;
  assign dividend = (DW'(k_sel) << FRAC_BITS) + DW'(last >> 1);

  logic dv_valid [DIV_CELLS+1];
  logic dv_ready [DIV_CELLS+1];
  logic [LW-1:0]      dv_rem  [DIV_CELLS+1];
  logic [PHASE_W-1:0] dv_num  [DIV_CELLS+1];
  logic [PHASE_W-1:0] dv_quo  [DIV_CELLS+1];
  spt_side_t          dv_side [DIV_CELLS+1];

  assign item_ready = !va || dv_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (item_ready) begin
      va <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      a_rem              <= LW'(dividend >> PHASE_W);
      a_num              <= dividend[PHASE_W-1:0];
      a_side.start_value <= item.start_value;
      a_side.diff        <= DIFF_W'(item.end_value) - DIFF_W'(item.start_value);
      a_side.last_node   <= at_end;
    end
  end

  // ---------------------------------------------------------------------
  // Divider chain: cell i decides phase bit PHASE_W-1-i.
  // ---------------------------------------------------------------------
  assign dv_valid[0] = va;
  assign dv_rem[0]   = a_rem;
  assign dv_num[0]   = a_num;
  assign dv_quo[0]   = '0;
  assign dv_side[0]  = a_side;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    spt_div_cell #(
      .LW  (LW),
      .BIT (PHASE_W - 1 - i)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .last      (last),
      .in_valid  (dv_valid[i]),
      .in_ready  (dv_ready[i]),
      .rem_in    (dv_rem[i]),
      .num_in    (dv_num[i]),
      .quo_in    (dv_quo[i]),
      .side_in   (dv_side[i]),
      .out_valid (dv_valid[i+1]),
      .out_ready (dv_ready[i+1]),
      .rem_out   (dv_rem[i+1]),
      .num_out   (dv_num[i+1]),
      .quo_out   (dv_quo[i+1]),
      .side_out  (dv_side[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // First Horner term: 70*p, exact.
  // ---------------------------------------------------------------------
  logic                       hv;
  logic signed [HORNER_W-1:0] h0;
  spt_horner_t                h0_aux;

  logic hr_valid [HORNER_STEPS+1];
  logic hr_ready [HORNER_STEPS+1];
  logic signed [HORNER_W-1:0] hr_val [HORNER_STEPS+1];
  logic [HAW-1:0]             hr_aux [HORNER_STEPS+1];

  assign dv_ready[DIV_CELLS] = !hv || hr_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
    end else if (dv_ready[DIV_CELLS]) begin
      hv <= dv_valid[DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ready[DIV_CELLS] && dv_valid[DIV_CELLS]) begin
      h0           <= HORNER_W'(dv_quo[DIV_CELLS]) * HORNER_W'(COEF_9);
      h0_aux.phase <= dv_quo[DIV_CELLS];
      h0_aux.side  <= dv_side[DIV_CELLS];
    end
  end

  // ---------------------------------------------------------------------
  // Horner chain: h = round(h*p) + c for c = -315, 540, -420, 126, then
  // five more multiplications by p (c = 0) give p^5 * (...).
  // ---------------------------------------------------------------------
  assign hr_valid[0] = hv;
  assign hr_val[0]   = h0;
  assign hr_aux[0]   = h0_aux;

  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
    spt_horner_t           hs;
    logic signed [PHASE_W:0] hb;

    assign hs = hr_aux[i];
    assign hb = {1'b0, hs.phase};

    spt_mul_cell #(
      .AW   (HORNER_W),
      .BW   (PHASE_W + 1),
      .OW   (HORNER_W),
      .CW   (HAW),
      .COEF (HORNER_COEF[i])
    ) u_mul (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (hr_valid[i]),
      .in_ready  (hr_ready[i]),
      .a         (hr_val[i]),
      .b         (hb),
      .aux_in    (hr_aux[i]),
      .out_valid (hr_valid[i+1]),
      .out_ready (hr_ready[i+1]),
      .y         (hr_val[i+1]),
      .aux_out   (hr_aux[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Scale the span by the blend: round((end - start) * blend / 2^24).
  // ---------------------------------------------------------------------
  spt_horner_t               hf;
  spt_tail_t                 tail_in;
  logic signed [BLEND_W-1:0] blend;
  logic                      tv;
  logic                      o_ready;
  logic signed [TAIL_W-1:0]  tail_y;
  logic [TAW-1:0]            tail_aux;

  assign hf                  = hr_aux[HORNER_STEPS];
  assign tail_in.start_value = hf.side.start_value;
  assign tail_in.last_node   = hf.side.last_node;
  assign blend               = hr_val[HORNER_STEPS][BLEND_W-1:0];

  spt_mul_cell #(
    .AW   (DIFF_W),
    .BW   (BLEND_W),
    .OW   (TAIL_W),
    .CW   (TAW),
    .COEF (0)
  ) u_tail (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hr_valid[HORNER_STEPS]),
    .in_ready  (hr_ready[HORNER_STEPS]),
    .a         (hf.side.diff),
    .b         (blend),
    .aux_in    (tail_in),
    .out_valid (tv),
    .out_ready (o_ready),
    .y         (tail_y),
    .aux_out   (tail_aux)
  );

  // ---------------------------------------------------------------------
  // Output register: start + scaled span, saturated to signed Q15.16.
  // ---------------------------------------------------------------------
  spt_tail_t               tt;
  logic signed [SUM_W-1:0] sum;
  logic                    ov_hi;
  logic                    ov_lo;
  logic [POS_W-1:0]        pos;

  assign tt    = tail_aux;
  assign sum   = SUM_W'(tt.start_value) + SUM_W'(tail_y);
  assign ov_hi = !sum[SUM_W-1] && (|sum[SUM_W-2:POS_W-1]);
  assign ov_lo = sum[SUM_W-1] && !(&sum[SUM_W-2:POS_W-1]);

  always_comb begin
    if (ov_hi) begin
      pos = {1'b0, {(POS_W - 1){1'b1}}};
    end else if (ov_lo) begin
      pos = {1'b1, {(POS_W - 1){1'b0}}};
    end else begin
      pos = sum[POS_W-1:0];
    end
  end

  assign o_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (o_ready) begin
      result_valid <= tv;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && tv) begin
      result.position  <= pos;
      result.last_node <= tt.last_node;
    end
  end

endmodule

@@ tb/smooth_polynomial_trajectory_point_test.sv @@
module smooth_polynomial_trajectory_point_test;
  import spt_pkg::*;

  localparam int MAX_NODES      = 65536;
  localparam int PIPE_LATENCY   = 48;      // transfer in to result valid
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int LONG_HOLD      = 400;     // output stall, far past pipeline depth
  localparam int HOLD_AT_FIRST  = 260;
  localparam int HOLD_AT_SECOND = 800;
  localparam int REPORT_LIMIT   = 10;

  localparam longint ONE_Q  = longint'(1) << FRAC_BITS;
  localparam longint POS_HI = 64'sd2147483647;
  localparam longint POS_LO = -64'sd2147483648;

  localparam logic [POS_W-1:0] POS_TOP    = 32'h7FFF_FFFF;
  localparam logic [POS_W-1:0] POS_BOTTOM = 32'h8000_0000;
  localparam logic [POS_W-1:0] POS_UNIT   = 32'h0001_0000;  // 1.0 in Q15.16

  logic                clk;
  logic                rst          = 1'b1;
  logic                cfg_we       = 1'b0;
  logic [NCOUNT_W-1:0] cfg_data     = '0;
  logic                item_valid   = 1'b0;
  logic                item_ready;
  spt_in_t             item         = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  spt_out_t            result;

  smooth_polynomial_trajectory_point #(
    .MAX_NODES(MAX_NODES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  // Points waiting to be offered, and blended positions waiting to come out.
  spt_in_t  pending_points[$];
  spt_out_t expected_positions[$];

  // Our copy of the node count register; only changes while the pipe is empty.
  logic [NCOUNT_W-1:0] node_count_now = 17'd2;

  int  queued_total    = 0;
  int  accepted_total  = 0;
  int  results_seen    = 0;
  int  last_nodes_seen = 0;
  int  mismatches      = 0;
  int  settings_seen   = 1;   // reset value counts as the first setting
  int  send_gap        = 0;
  int  stall_left      = 0;
  bit  tx_steady       = 1'b0;  // sender offers back to back
  bit  rx_steady       = 1'b0;  // receiver draws no random stalls

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Last node index after the register is clamped to [2, MAX_NODES].
  function automatic longint unsigned eff_last(logic [NCOUNT_W-1:0] count);
    longint unsigned n;
    n = count;
    if (n < 2) n = 2;
    if (n > MAX_NODES) n = MAX_NODES;
    return n - 1;
  endfunction

  // a*b scaled down by the phase fraction, nearest, halves away from zero.
  function automatic longint round_frac(longint a, longint b);
    bit              neg;
    longint unsigned ma, mb, mag;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    mag = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic spt_out_t predict_point(spt_in_t pt, logic [NCOUNT_W-1:0] count);
    longint unsigned last, k, p;
    longint          h, diff, pos;
    spt_out_t        res;
    last = eff_last(count);
    k    = pt.node_index;
    if (k > last) k = last;   // index past the end lands on the last node
    // phase k/last in Q1.24, halves up
    p = ((k << FRAC_BITS) + (last >> 1)) / last;
    // Horner over the high coefficients, then five more factors of p
    h = COEF_9 * longint'(p);
    h = round_frac(h, p) - COEF_8 * ONE_Q;
    h = round_frac(h, p) + COEF_7 * ONE_Q;
    h = round_frac(h, p) - COEF_6 * ONE_Q;
    h = round_frac(h, p) + COEF_5 * ONE_Q;
    repeat (5) h = round_frac(h, p);
    diff = longint'(pt.end_value) - longint'(pt.start_value);
    pos  = longint'(pt.start_value) + round_frac(diff, h);
    if (pos > POS_HI) pos = POS_HI;
    if (pos < POS_LO) pos = POS_LO;
    res.position  = pos[POS_W-1:0];
    res.last_node = (k == last);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mix of full scale, sign edges, small moves and raw random bits.
  function automatic logic [POS_W-1:0] rand_position();
    case ($urandom_range(0, 9))
      0:       return POS_BOTTOM;
      1:       return POS_TOP;
      2:       return '0;
      3:       return '1;
      4, 5:    return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      default: return $urandom();
    endcase
  endfunction

  // Biased toward the ends of the transition and past it.
  function automatic logic [INDEX_W-1:0] rand_index(longint unsigned last);
    int unsigned hi;
    hi = last;
    case ($urandom_range(0, 9))
      0, 1:    return hi;
      2:       return (hi < 65535) ? $urandom_range(hi + 1, 65535) : $urandom_range(0, 65535);
      3:       return '0;
      4, 5:    return $urandom_range(0, 65535);
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  task automatic push_point(logic [INDEX_W-1:0] idx, logic [POS_W-1:0] from_pos,
                            logic [POS_W-1:0] to_pos);
    spt_in_t pt;
    pt.node_index  = idx;
    pt.start_value = from_pos;
    pt.end_value   = to_pos;
    pending_points = {pending_points, pt};
    queued_total++;
  endtask

  task automatic push_random(int n);
    repeat (n) push_point(rand_index(eff_last(node_count_now)), rand_position(),
                          rand_position());
  endtask

  // Every point gives a result, so an empty queue means an idle pipe.
  // Sampled on the falling edge, away from the driver and monitor.
  task automatic wait_drained();
    while (accepted_total != queued_total || expected_positions.size() != 0)
      @(negedge clk);
  endtask

  task automatic apply_count(logic [NCOUNT_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we         <= 1'b0;
    node_count_now  = value;
    settings_seen++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers pending points, predicts each one on its transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (item_valid && item_ready) begin
        expected_positions = {expected_positions, predict_point(item, node_count_now)};
        accepted_total++;
      end
      // slot is free when nothing is offered or the offer just went through
      if (!item_valid || item_ready) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          item_valid <= 1'b0;
        end else if (pending_points.size() != 0) begin
          item       <= pending_points.pop_front();
          item_valid <= 1'b1;
          send_gap   <= tx_steady ? 0 : $urandom_range(0, 7);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer, then draws its own stall.
  // Twice in the run it holds ready low long enough to back the pipe up.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : receiver
    int       pause;
    spt_out_t want;
    if (rst) begin
      result_ready <= 1'b0;
      stall_left   <= 0;
    end else if (result_valid && result_ready) begin
      if (expected_positions.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: position %h last_node %b, nothing outstanding",
                   result.position, result.last_node);
      end else begin
        want = expected_positions.pop_front();
        if (result.position !== want.position || result.last_node !== want.last_node) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result %0d: position %h (expected %h), last_node %b (expected %b)",
                     results_seen, result.position, want.position,
                     result.last_node, want.last_node);
        end
        if (want.last_node) last_nodes_seen++;
      end
      results_seen++;
      if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_SECOND)
        pause = LONG_HOLD;
      else
        pause = rx_steady ? 0 : $urandom_range(0, 7);
      stall_left   <= pause;
      result_ready <= (pause == 0);
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      result_ready <= (stall_left == 1);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, then one phase per node count setting.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset value: two nodes, so only start and end exist.
    push_point(16'd0, 32'h0, POS_TOP);
    push_point(16'd1, POS_BOTTOM, POS_TOP);
    push_point(16'hFFFF, POS_TOP, POS_BOTTOM);   // past the end, clamped
    push_point(16'd0, POS_BOTTOM, POS_TOP);
    push_point(16'd2, POS_UNIT, -POS_UNIT);
    push_random(60);

    // Counts of zero and one behave like two.
    apply_count(17'd0);
    push_point(16'd0, POS_TOP, POS_BOTTOM);
    push_point(16'd7, '1, POS_UNIT);
    push_random(40);
    apply_count(17'd1);
    push_point(16'd1, POS_BOTTOM, '0);
    push_random(40);

    apply_count(17'd3);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    push_random(80);

    // Largest legal count; sender runs flat out so the long hold fills the pipe.
    apply_count(MAX_NODES);
    rx_steady = 1'b0;
    push_point(16'd32768, POS_BOTTOM, POS_TOP);
    push_point(16'hFFFF, POS_BOTTOM, POS_TOP);
    push_point(16'd1, POS_TOP, POS_BOTTOM);
    push_point(16'hFFFE, POS_TOP, POS_BOTTOM);
    push_random(200);

    // Counts above the maximum clamp to it.
    apply_count(17'h1FFFF);
    tx_steady = 1'b0;
    push_point(16'hFFFF, 32'h1234_5678, 32'h8765_4321);
    push_point(16'd0, 32'h1234_5678, 32'h8765_4321);
    push_random(60);
    apply_count(MAX_NODES + 1);
    push_random(40);
    apply_count(MAX_NODES - 1);
    rx_steady = 1'b1;
    push_random(80);

    apply_count($urandom_range(4, 200));
    rx_steady = 1'b0;
    push_random(150);
    apply_count($urandom_range(2, 131071));
    push_random(150);
    apply_count(17'd1000);
    tx_steady = 1'b1;
    push_random(150);

    wait_drained();
    repeat (PIPE_LATENCY + 16) @(posedge clk);

    $display("Checked %0d trajectory points over %0d node-count settings, %0d at the last node.",
             results_seen, settings_seen, last_nodes_seen);
    $display("Counts from 0 to 131071, clamped indices, full-scale moves, %0d-cycle stalls; %0d bad.",
             LONG_HOLD, mismatches);
    if (mismatches == 0 && expected_positions.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("Timed out with %0d results outstanding.", expected_positions.size());
    $display("FAILURE");
    $finish;
  end

endmodule
